@@ hw/rtl/hrhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, character codes and method tables for the HTTP request
// header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int MAX_RES = 3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_MSKIP,
        PH_URL,
        PH_VERSION,
        PH_VERSION_CR,
        PH_LINE,
        PH_LINE_CR,
        PH_NAME,
        PH_WS,
        PH_VALUE,
        PH_VALUE_CR
    } phase_t;

    typedef enum logic [2:0] {
        K_METHOD,
        K_URL,
        K_VERSION,
        K_NAME,
        K_VALUE,
        K_HDONE,
        K_RDONE
    } kind_t;

    typedef enum logic [2:0] {
        M_GET,
        M_POST,
        M_PUT,
        M_PATCH,
        M_DELETE
    } meth_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        meth_t      code;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0]               cnt;
        res_t [MAX_RES-1:0]       ent;
    } batch_t;

    // Length of each method name.
    function automatic logic [2:0] meth_len(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'(M_GET):    r = 3'd3;
            3'(M_POST):   r = 3'd4;
            3'(M_PUT):    r = 3'd3;
            3'(M_PATCH):  r = 3'd5;
            3'(M_DELETE): r = 3'd6;
            default:      r = 3'd0;
        endcase
        return r;
    endfunction

    // Character at position pos of method c; zero past the end.
    function automatic logic [7:0] meth_char(input logic [2:0] c, input logic [3:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (c)
            3'(M_GET): begin
                case (pos)
                    4'd0:    r = "G";
                    4'd1:    r = "E";
                    4'd2:    r = "T";
                    default: r = 8'h00;
                endcase
            end
            3'(M_POST): begin
                case (pos)
                    4'd0:    r = "P";
                    4'd1:    r = "O";
                    4'd2:    r = "S";
                    4'd3:    r = "T";
                    default: r = 8'h00;
                endcase
            end
            3'(M_PUT): begin
                case (pos)
                    4'd0:    r = "P";
                    4'd1:    r = "U";
                    4'd2:    r = "T";
                    default: r = 8'h00;
                endcase
            end
            3'(M_PATCH): begin
                case (pos)
                    4'd0:    r = "P";
                    4'd1:    r = "A";
                    4'd2:    r = "T";
                    4'd3:    r = "C";
                    4'd4:    r = "H";
                    default: r = 8'h00;
                endcase
            end
            3'(M_DELETE): begin
                case (pos)
                    4'd0:    r = "D";
                    4'd1:    r = "E";
                    4'd2:    r = "L";
                    4'd3:    r = "E";
                    4'd4:    r = "T";
                    4'd5:    r = "E";
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Drop candidates that cannot match byte b at position pos.
    function automatic logic [4:0] meth_match(input logic [4:0] cand, input logic [3:0] pos,
                                              input logic [7:0] b);
        logic [4:0] r;
        r = cand;
        for (int c = 0; c < 5; c++) begin
            if ({1'b0, pos} >= {2'b00, meth_len(3'(c))} || meth_char(3'(c), pos) != b) begin
                r[c] = 1'b0;
            end
        end
        return r;
    endfunction

    // Lowest surviving candidate whose length equals len; GET when none.
    function automatic meth_t meth_pick(input logic [4:0] cand, input logic [3:0] len);
        meth_t r;
        r = M_GET;
        for (int c = 4; c >= 0; c--) begin
            if (cand[c] && {1'b0, meth_len(3'(c))} == len) begin
                r = meth_t'(3'(c));
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/http_request_header_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser_top
// Streaming HTTP request header parser: one request byte per transfer in,
// tagged method, URL, version, header and done results out.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_       in   s_valid/s_ready    s_in_byte[7:0], s_is_final
//  m_       out  m_valid/m_ready    m_kind[2:0], m_data_byte[7:0],
//                                   m_method_code[2:0], m_run_end
//
//  A byte is parsed in the cycle it is taken; its results (zero to three)
//  appear on m_ from the next cycle, one per cycle while m_ready is high.
//  Sustained rate is one byte per cycle while each byte makes at most one
//  result and m_ready stays high; a byte making several results holds the
//  result port until all have left, and s_ready stays low until the result
//  queue is empty or its last result leaves in that cycle.
//  aresetn (synchronous) returns the parser to the method phase and empties
//  the result queue.
// ----------------------------------------------------------------------------
module http_request_header_parser_top
    import hrhp_pkg::*;
#(
    parameter int METHOD_CAPACITY = 16,
    parameter int VERSION_LIMIT   = 16,
    parameter int NAME_LIMIT      = 64,
    parameter int VALUE_LIMIT     = 256
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_method_code,
    output logic       m_run_end
);

    localparam int MLEN_W = $clog2(METHOD_CAPACITY);
    localparam int FMAX_A = (VERSION_LIMIT > NAME_LIMIT) ? VERSION_LIMIT : NAME_LIMIT;
    localparam int FMAX   = (FMAX_A > VALUE_LIMIT) ? FMAX_A : VALUE_LIMIT;
    localparam int FLEN_W = $clog2(FMAX);

    localparam logic [MLEN_W-1:0] MLEN_END = MLEN_W'(METHOD_CAPACITY - 1);
    localparam logic [FLEN_W-1:0] VER_MAX  = FLEN_W'(VERSION_LIMIT - 1);
    localparam logic [FLEN_W-1:0] NAME_MAX = FLEN_W'(NAME_LIMIT - 1);
    localparam logic [FLEN_W-1:0] VAL_MAX  = FLEN_W'(VALUE_LIMIT - 1);

    phase_t            phase_reg,  phase_next;
    logic [4:0]        cand_reg,   cand_next;
    logic [MLEN_W-1:0] mlen_reg,   mlen_next;
    logic [FLEN_W-1:0] flen_reg,   flen_next;
    logic              fin_reg,    fin_next;

    logic   s_xfer;
    logic   room;
    batch_t batch;
    res_t   head;

    assign s_ready = room;
    assign s_xfer  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Per-byte parse: resolve the phase chain and collect results.
    // ------------------------------------------------------------------
    always_comb begin
        phase_t            ph;
        logic [4:0]        cand;
        logic [MLEN_W-1:0] mlen;
        logic [FLEN_W-1:0] flen;
        logic              rf;
        logic              go;
        logic [1:0]        n;
        logic [7:0]        b;
        logic              crlf;

        ph    = phase_reg;
        cand  = cand_reg;
        mlen  = mlen_reg;
        flen  = flen_reg;
        rf    = fin_reg;
        go    = 1'b0;
        n     = 2'd0;
        b     = s_in_byte;
        crlf  = (b == CH_CR) || (b == CH_LF);
        batch = '0;

        if (!fin_reg) begin
            go = 1'b1;
            // a byte passes through at most four phases
            for (int i = 0; i < 4; i++) begin
                if (go) begin
                    go = 1'b0;
                    case (ph)
                        PH_METHOD: begin
                            if (b == CH_SP) begin
                                batch.ent[n] = '{K_METHOD, 8'h00,
                                                 meth_pick(cand, 4'(mlen)), 1'b0};
                                n  = n + 2'd1;
                                ph = PH_URL;
                            end else begin
                                cand = meth_match(cand, 4'(mlen), b);
                                mlen = mlen + 1'b1;
                                if (mlen >= MLEN_END) begin
                                    batch.ent[n] = '{K_METHOD, 8'h00,
                                                     meth_pick(cand, 4'(mlen)), 1'b0};
                                    n  = n + 2'd1;
                                    ph = PH_MSKIP;
                                end
                            end
                        end
                        PH_MSKIP: begin
                            ph = PH_URL;
                        end
                        PH_URL: begin
                            if (b == CH_SP || crlf) begin
                                ph   = PH_VERSION;
                                flen = '0;
                            end else begin
                                batch.ent[n] = '{K_URL, b, M_GET, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                        PH_VERSION: begin
                            if (b == CH_CR) begin
                                ph = PH_VERSION_CR;
                            end else if (b == CH_LF) begin
                                ph = PH_LINE;
                            end else if (flen < VER_MAX) begin
                                batch.ent[n] = '{K_VERSION, b, M_GET, 1'b0};
                                n    = n + 2'd1;
                                flen = flen + 1'b1;
                            end
                        end
                        PH_VERSION_CR, PH_VALUE_CR: begin
                            ph = PH_LINE;
                            go = (b != CH_LF);
                        end
                        PH_LINE: begin
                            if (b == CH_CR) begin
                                ph = PH_LINE_CR;
                            end else begin
                                ph   = PH_NAME;
                                flen = '0;
                                go   = 1'b1;
                            end
                        end
                        PH_LINE_CR: begin
                            if (b == CH_LF) begin
                                batch.ent[n] = '{K_RDONE, 8'h00, M_GET, 1'b0};
                                n  = n + 2'd1;
                                rf = 1'b1;
                            end else begin
                                ph = PH_WS;
                                go = 1'b1;
                            end
                        end
                        PH_NAME: begin
                            if (b == CH_COLON) begin
                                ph = PH_WS;
                            end else if (crlf) begin
                                ph = PH_WS;
                                go = 1'b1;
                            end else if (flen < NAME_MAX) begin
                                batch.ent[n] = '{K_NAME, b, M_GET, 1'b0};
                                n    = n + 2'd1;
                                flen = flen + 1'b1;
                            end
                        end
                        PH_WS: begin
                            if (!(b == CH_SP || crlf)) begin
                                ph   = PH_VALUE;
                                flen = '0;
                                go   = 1'b1;
                            end
                        end
                        PH_VALUE: begin
                            if (crlf) begin
                                batch.ent[n] = '{K_HDONE, 8'h00, M_GET, 1'b0};
                                n  = n + 2'd1;
                                ph = (b == CH_CR) ? PH_VALUE_CR : PH_LINE;
                            end else if (flen < VAL_MAX) begin
                                batch.ent[n] = '{K_VALUE, b, M_GET, 1'b0};
                                n    = n + 2'd1;
                                flen = flen + 1'b1;
                            end
                        end
                        default: begin
                            ph = PH_METHOD;
                        end
                    endcase
                end
            end

            // Close out whatever is open at the last byte.
            if (s_is_final && !rf) begin
                if (ph == PH_METHOD) begin
                    batch.ent[n] = '{K_METHOD, 8'h00, meth_pick(cand, 4'(mlen)), 1'b0};
                    n = n + 2'd1;
                end
                if (ph == PH_NAME || ph == PH_WS || ph == PH_VALUE || ph == PH_LINE_CR) begin
                    batch.ent[n] = '{K_HDONE, 8'h00, M_GET, 1'b0};
                    n = n + 2'd1;
                end
                batch.ent[n] = '{K_RDONE, 8'h00, M_GET, 1'b0};
                n = n + 2'd1;
            end
        end

        if (n != 2'd0) begin
            batch.ent[n - 2'd1].last = 1'b1;
        end
        batch.cnt = n;

        if (s_is_final) begin
            phase_next = PH_METHOD;
            cand_next  = 5'h1F;
            mlen_next  = '0;
            flen_next  = '0;
            fin_next   = 1'b0;
        end else begin
            phase_next = ph;
            cand_next  = cand;
            mlen_next  = mlen;
            flen_next  = flen;
            fin_next   = rf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_METHOD;
            cand_reg  <= 5'h1F;
            mlen_reg  <= '0;
            flen_reg  <= '0;
            fin_reg   <= 1'b0;
        end else if (s_xfer) begin
            phase_reg <= phase_next;
            cand_reg  <= cand_next;
            mlen_reg  <= mlen_next;
            flen_reg  <= flen_next;
            fin_reg   <= fin_next;
        end
    end

    hrhp_res_q u_res_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s_xfer),
        .batch   (batch),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_kind        = head.kind;
    assign m_data_byte   = head.data;
    assign m_method_code = head.code;
    assign m_run_end     = head.last;

endmodule

@@ hw/rtl/hrhp_res_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_res_q
// Result queue: holds the results of one input byte and hands them out one
// transfer at a time, head first.
// ----------------------------------------------------------------------------
module hrhp_res_q
    import hrhp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  batch_t batch,
    output logic   room,
    output logic   m_valid,
    input  logic   m_ready,
    output res_t   head
);

    res_t [MAX_RES-1:0] ent_reg;
    logic [1:0]         cnt_reg;
    logic               pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign head    = ent_reg[0];
    // Free when empty, or once the last queued result leaves in this cycle.
    assign room    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= batch.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg <= batch.ent;
        end else if (pop) begin
            // advance the queue by one entry
            for (int i = 0; i < MAX_RES - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
    end

endmodule

@@ bench/http_request_header_parser_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser_top_tb
// Self-checking bench for the streaming HTTP request header parser. Requests
// go in one byte per transfer with random gaps, and results leave under
// random back-pressure. A behavioral parser in the bench predicts the tagged
// results of every byte, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module http_request_header_parser_top_tb
    import hrhp_pkg::*;
();

    localparam int METHOD_CAPACITY = 16;
    localparam int VERSION_LIMIT   = 16;
    localparam int NAME_LIMIT      = 64;
    localparam int VALUE_LIMIT     = 256;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        meth_t      code;
        logic       last;
    } token_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_is_final;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_kind;
    logic [7:0] m_data_byte;
    logic [2:0] m_method_code;
    logic       m_run_end;

    // Parser state mirrored by the bench.
    phase_t     pr_phase;
    logic [4:0] pr_cand;
    logic [4:0] pr_mlen;
    logic [8:0] pr_flen;
    logic       pr_done;

    token_t     tokens_due[$];
    logic [7:0] req_bytes[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int requests_sent  = 0;
    int tokens_checked = 0;
    int src_calm       = 0;
    int sink_calm      = 0;

    http_request_header_parser_top #(
        .METHOD_CAPACITY (METHOD_CAPACITY),
        .VERSION_LIMIT   (VERSION_LIMIT),
        .NAME_LIMIT      (NAME_LIMIT),
        .VALUE_LIMIT     (VALUE_LIMIT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_is_final    (s_is_final),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_method_code (m_method_code),
        .m_run_end     (m_run_end)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------
    function automatic string method_text(meth_t m);
        case (m)
            M_GET:    return "GET";
            M_POST:   return "POST";
            M_PUT:    return "PUT";
            M_PATCH:  return "PATCH";
            M_DELETE: return "DELETE";
            default:  return "";
        endcase
    endfunction

    // Lowest surviving method whose full length has been seen; GET otherwise.
    function automatic meth_t matched_method();
        string name;
        for (int c = 0; c < 5; c++) begin
            name = method_text(meth_t'(c));
            if (pr_cand[c] && name.len() == pr_mlen)
                return meth_t'(c);
        end
        return M_GET;
    endfunction

    function automatic token_t tok(kind_t k, logic [7:0] d, meth_t m);
        token_t t;
        t.kind = k;
        t.data = d;
        t.code = m;
        t.last = 1'b0;
        return t;
    endfunction

    task automatic clear_parser();
        pr_phase = PH_METHOD;
        pr_cand  = 5'h1F;
        pr_mlen  = '0;
        pr_flen  = '0;
        pr_done  = 1'b0;
    endtask

    task automatic parse_request_byte(input logic [7:0] b, input logic fin);
        token_t batch[$];
        logic   again;
        logic   crlf;
        string  name;
        crlf = (b == CH_CR) || (b == CH_LF);
        if (!pr_done) begin
            do begin
                again = 1'b0;
                case (pr_phase)
                    PH_METHOD: begin
                        if (b == CH_SP) begin
                            batch.push_back(tok(K_METHOD, 8'h00, matched_method()));
                            pr_phase = PH_URL;
                        end else begin
                            for (int c = 0; c < 5; c++) begin
                                name = method_text(meth_t'(c));
                                if (pr_mlen >= name.len() || name[pr_mlen] != b)
                                    pr_cand[c] = 1'b0;
                            end
                            pr_mlen = pr_mlen + 5'd1;
                            if (pr_mlen >= METHOD_CAPACITY - 1) begin
                                batch.push_back(tok(K_METHOD, 8'h00, matched_method()));
                                pr_phase = PH_MSKIP;
                            end
                        end
                    end
                    PH_MSKIP: pr_phase = PH_URL;
                    PH_URL: begin
                        if (b == CH_SP || crlf) begin
                            pr_phase = PH_VERSION;
                            pr_flen  = '0;
                        end else begin
                            batch.push_back(tok(K_URL, b, M_GET));
                        end
                    end
                    PH_VERSION: begin
                        if (b == CH_CR) begin
                            pr_phase = PH_VERSION_CR;
                        end else if (b == CH_LF) begin
                            pr_phase = PH_LINE;
                        end else if (pr_flen < VERSION_LIMIT - 1) begin
                            batch.push_back(tok(K_VERSION, b, M_GET));
                            pr_flen = pr_flen + 9'd1;
                        end
                    end
                    PH_VERSION_CR, PH_VALUE_CR: begin
                        pr_phase = PH_LINE;
                        if (b != CH_LF) again = 1'b1;
                    end
                    PH_LINE: begin
                        if (b == CH_CR) begin
                            pr_phase = PH_LINE_CR;
                        end else begin
                            pr_phase = PH_NAME;
                            pr_flen  = '0;
                            again    = 1'b1;
                        end
                    end
                    PH_LINE_CR: begin
                        if (b == CH_LF) begin
                            batch.push_back(tok(K_RDONE, 8'h00, M_GET));
                            pr_done = 1'b1;
                        end else begin
                            pr_phase = PH_WS;
                            again    = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        if (b == CH_COLON) begin
                            pr_phase = PH_WS;
                        end else if (crlf) begin
                            pr_phase = PH_WS;
                            again    = 1'b1;
                        end else if (pr_flen < NAME_LIMIT - 1) begin
                            batch.push_back(tok(K_NAME, b, M_GET));
                            pr_flen = pr_flen + 9'd1;
                        end
                    end
                    PH_WS: begin
                        if (!(b == CH_SP || crlf)) begin
                            pr_phase = PH_VALUE;
                            pr_flen  = '0;
                            again    = 1'b1;
                        end
                    end
                    PH_VALUE: begin
                        if (crlf) begin
                            batch.push_back(tok(K_HDONE, 8'h00, M_GET));
                            pr_phase = (b == CH_CR) ? PH_VALUE_CR : PH_LINE;
                        end else if (pr_flen < VALUE_LIMIT - 1) begin
                            batch.push_back(tok(K_VALUE, b, M_GET));
                            pr_flen = pr_flen + 9'd1;
                        end
                    end
                    default: pr_phase = PH_METHOD;
                endcase
            end while (again);

            if (fin && !pr_done) begin
                if (pr_phase == PH_METHOD)
                    batch.push_back(tok(K_METHOD, 8'h00, matched_method()));
                if (pr_phase == PH_NAME || pr_phase == PH_WS || pr_phase == PH_VALUE ||
                    pr_phase == PH_LINE_CR)
                    batch.push_back(tok(K_HDONE, 8'h00, M_GET));
                batch.push_back(tok(K_RDONE, 8'h00, M_GET));
            end
        end
        if (fin) clear_parser();
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) tokens_due.push_back(batch[i]);
    endtask

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    // Random wait, with occasional stretches of none.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 9);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_byte  <= b;
        s_is_final <= fin;
        parse_request_byte(b, fin);
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endtask

    task automatic add_byte(input logic [7:0] b);
        req_bytes.push_back(b);
    endtask

    task automatic add_eol();
        case ($urandom_range(0, 5))
            4:       add_byte(CH_LF);
            5:       add_byte(CH_CR);
            default: add_text("\015\n");
        endcase
    endtask

    // Send the collected bytes; the final flag, when with_final is set, rides on the last one.
    task automatic send_request(input logic with_final);
        for (int i = 0; i < req_bytes.size(); i++)
            send_byte(req_bytes[i], with_final && (i == req_bytes.size() - 1));
        req_bytes.delete();
        requests_sent++;
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_request(1'b1);
    endtask

    task automatic check_token();
        token_t want;
        if (tokens_due.size() == 0) begin
            $error("result with nothing expected: kind %0d data %0h", m_kind, m_data_byte);
            errors++;
            return;
        end
        want = tokens_due.pop_front();
        tokens_checked++;
        if (m_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_kind);
            errors++;
        end
        if (m_data_byte !== want.data) begin
            $error("data_byte: expected %0h, got %0h", want.data, m_data_byte);
            errors++;
        end
        if (m_method_code !== want.code) begin
            $error("method_code: expected %0d, got %0d", want.code, m_method_code);
            errors++;
        end
        if (m_run_end !== want.last) begin
            $error("run_end: expected %0b, got %0b", want.last, m_run_end);
            errors++;
        end
    endtask

    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_token();
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_methods();
        send_text("GET /");
        send_text("POST /");
        send_text("PUT /");
        send_text("PATCH /");
        send_text("DELETE /");
        send_text("PU /");      // prefix of a method: falls back to GET
        send_text("GETS /");    // too long for GET
        send_text(" /");        // empty method
        send_text("DELETE");    // request ends inside the method
    endtask

    task automatic test_method_overflow();
        // 15 method bytes end the method, the next byte is skipped
        send_text("ABCDEFGHIJKLMNO/u V\n");
        send_text("DELETEDELETEDEL V\n");
    endtask

    task automatic test_line_ends();
        // URL ended by CR, whitespace skipped across a line end, body ignored
        send_text("GET /a\015HTTP\015\nHost:  \015\n x\n\015\nzz");
        // CR in version not followed by LF, value closed by CR CR
        send_text("GET /b\nV\015X:y\015\015\n");
        // lone CR at the start of a line gives an empty name
        send_text("GET / V\n\015Z\nN\n");
        // name closed by CR without colon
        send_text("GET / V\nAb\015\nv\n");
        // NUL bytes in every field
        add_text("P");
        add_byte(8'h00);
        add_text(" /");
        add_byte(8'h00);
        add_text(" V");
        add_byte(8'h00);
        add_text("\n");
        add_byte(8'h00);
        add_text(":");
        add_byte(8'h00);
        add_text("\015\n\015\n");
        send_request(1'b1);
        // request without a final byte, then body until the final one
        add_text("PUT / V\015\n\015\n");
        send_request(1'b0);
        send_text("body");
    endtask

    task automatic test_final_phases();
        send_text("X");
        send_text(" ");
        send_text("GE");
        send_text("ABCDEFGHIJKLMNOP");
        send_text("GET /x");
        send_text("GET / HT");
        send_text("GET / H\015");
        send_text("GET / H\n");
        send_text("GET / H\n\015");
        send_text("GET / H\nAb");
        send_text("GET / H\nA:");
        send_text("GET / H\nA: v");
        send_text("GET / H\nA: v\015");
        send_text("GET / H\n\015\n");
        send_text("GET / H\n\015\nbody");
    endtask

    task automatic test_field_limits();
        add_text("POST /l ");
        repeat (VERSION_LIMIT + 4) add_byte(8'($urandom_range(33, 255)));
        add_text("\015\n");
        repeat (NAME_LIMIT + 6) add_byte("n");
        add_text(": ");
        repeat (VALUE_LIMIT + 4) add_byte(8'($urandom_range(128, 255)));
        add_text("\015\n\015\n");
        send_request(1'b1);
    endtask

    task automatic test_random_requests();
        int         start;
        int         n;
        int         pos;
        logic [7:0] fill;
        start = bytes_sent;
        while (bytes_sent - start < 320) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise
                n = $urandom_range(1, 12);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 6))
                    5: begin
                        n = $urandom_range(0, 16);
                        repeat (n) add_byte(8'($urandom_range("A", "Z")));
                    end
                    6: begin
                        n = $urandom_range(1, 4);
                        repeat (n) add_byte(8'($urandom_range(33, 255)));
                    end
                    default: add_text(method_text(meth_t'($urandom_range(0, 4))));
                endcase
                add_byte(CH_SP);
                add_byte("/");
                n = $urandom_range(0, 8);
                repeat (n) add_byte(8'($urandom_range(33, 255)));
                add_byte(CH_SP);
                if ($urandom_range(0, 3) != 0) begin
                    add_text("HTTP/1.1");
                end else begin
                    n = $urandom_range(0, 18);
                    repeat (n) add_byte(8'($urandom_range(33, 255)));
                end
                add_eol();
                n = $urandom_range(0, 3);
                repeat (n) begin
                    repeat ($urandom_range(0, 6)) begin
                        fill = 8'($urandom_range(33, 255));
                        add_byte((fill == CH_COLON) ? 8'h78 : fill);
                    end
                    if ($urandom_range(0, 7) != 0) add_byte(CH_COLON);
                    repeat ($urandom_range(0, 2)) add_byte(CH_SP);
                    repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(33, 255)));
                    add_eol();
                end
                if ($urandom_range(0, 4) != 0) add_text("\015\n");
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));

                // break some requests: stray delimiters, early end
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        pos = $urandom_range(0, req_bytes.size() - 1);
                        case ($urandom_range(0, 4))
                            0:       req_bytes[pos] = CH_SP;
                            1:       req_bytes[pos] = CH_CR;
                            2:       req_bytes[pos] = CH_LF;
                            3:       req_bytes[pos] = CH_COLON;
                            default: req_bytes[pos] = 8'($urandom_range(0, 255));
                        endcase
                    end
                end
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(1, req_bytes.size());
                    while (req_bytes.size() > n) void'(req_bytes.pop_back());
                end
            end
            send_request(1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_in_byte  <= 8'h00;
        s_is_final <= 1'b0;
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_methods();
        test_method_overflow();
        test_line_ends();
        test_final_phases();
        test_field_limits();
        test_random_requests();

        s_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("parsed %0d requests (%0d bytes): all methods, line-end quirks,",
                 requests_sent, bytes_sent);
        $display("field limits, final byte in every phase; %0d results checked",
                 tokens_checked);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
